// File: rtl/core/round_robin_slice_scheduler_core_assert.svh
// Assertion macros shared by the scheduler checker.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define RRSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RRSS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/rrss_pkg.sv
// Package with the types and constants of the round-robin slice scheduler.
`timescale 1ns / 1ps
package rrss_pkg;

   localparam int CMD_W   = 2;
   localparam int BURST_W = 16;
   localparam int TS_W    = 16;
   localparam int TIME_W  = 20;
   localparam int ID_W    = 5;

   localparam logic [CMD_W-1:0]  CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0]  CMD_NEXT  = 2'd1;
   localparam logic [CMD_W-1:0]  CMD_CLEAR = 2'd2;

   localparam logic [TS_W-1:0]   TS_RESET  = 16'd4;
   localparam logic [TIME_W-1:0] CLOCK_MAX = 20'hFFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_SCAN,
      ST_HIT,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic start;
      logic first;
      logic advance;
      logic capture;
      logic commit;
      logic finish;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic hit;
      logic last;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/core/rrss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rrss_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/rrss_ctrl.sv
// Controller state machine of the round-robin slice scheduler.
`timescale 1ns / 1ps
module rrss_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [rrss_pkg::CMD_W-1:0] req_command,
   output logic                      req_ready,
   input  rrss_pkg::stat_type        stat,
   output rrss_pkg::ctl_type         ctl
);
   import rrss_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_LOAD: begin
                     ctl.load = !stat.full;
                  end
                  CMD_CLEAR: begin
                     ctl.clear = 1'b1;
                  end
                  CMD_NEXT: begin
                     if (stat.empty) begin
                        state_in = ST_DONE;
                     end else begin
                        ctl.start = 1'b1;
                        state_in  = ST_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FIRST: begin
            ctl.first = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // One table entry is checked per cycle while the next one is read.
            if (stat.hit) begin
               ctl.capture = 1'b1;
               state_in    = ST_HIT;
            end else if (stat.last) begin
               state_in = ST_DONE;
            end else begin
               ctl.advance = 1'b1;
            end
         end
         ST_HIT: begin
            if (stat.out_free) begin
               ctl.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/rrss_datapath.sv
// Datapath of the round-robin slice scheduler: table, clock, scan and result register.
`timescale 1ns / 1ps
module rrss_datapath #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rrss_pkg::ctl_type            ctl,
   output rrss_pkg::stat_type           stat,
   input  logic [rrss_pkg::BURST_W-1:0] req_burst_time,
   input  logic                         csr_valid,
   input  logic [rrss_pkg::TS_W-1:0]    csr_time_slice,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rrss_pkg::ID_W-1:0]    rsp_process_id,
   output logic [rrss_pkg::TIME_W-1:0]  rsp_start_time,
   output logic [rrss_pkg::TIME_W-1:0]  rsp_end_time,
   output logic                         rsp_all_done
);
   import rrss_pkg::*;

   localparam int IW = $clog2(MAX_PROCESSES);
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam int PW = (IW + 1 > ID_W) ? IW + 1 : ID_W;

   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      scan_ff, scan_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [TS_W-1:0]    ts_ff, ts_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [BURST_W-1:0] rem_ff, rem_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [TIME_W-1:0]  rsp_end_ff, rsp_end_in;
   logic               rsp_done_ff, rsp_done_in;

   logic [CW-1:0]      idx_inc;
   logic [IW-1:0]      idx_next;
   logic [IW-1:0]      idx_first;
   logic [TS_W-1:0]    quantum;
   logic [BURST_W-1:0] run;
   logic [TIME_W:0]    end_sum;
   logic [TIME_W-1:0]  end_sat;
   logic [PW-1:0]      id_wide;
   logic               ram_wr_en;
   logic [IW-1:0]      ram_wr_addr;
   logic [BURST_W-1:0] ram_wr_data;
   logic [IW-1:0]      ram_rd_addr;
   logic [BURST_W-1:0] ram_rd_data;

   rrss_ram #(
      .WIDTH (BURST_W),
      .DEPTH (MAX_PROCESSES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      idx_inc   = CW'(idx_ff) + CW'(1);
      idx_next  = (idx_inc >= count_ff) ? '0 : idx_inc[IW-1:0];
      idx_first = (CW'(scan_ff) >= count_ff) ? '0 : scan_ff;
      // A quantum of zero behaves as one.
      quantum   = (ts_ff == '0) ? TS_W'(1) : ts_ff;
      run       = (rem_ff < quantum) ? rem_ff : quantum;
      end_sum   = {1'b0, time_ff} + (TIME_W + 1)'(run);
      end_sat   = (end_sum > {1'b0, CLOCK_MAX}) ? CLOCK_MAX : end_sum[TIME_W-1:0];
      id_wide   = PW'(idx_ff) + PW'(1);

      ram_rd_addr = ctl.first ? idx_ff : idx_next;
      ram_wr_en   = ctl.load | ctl.commit;
      ram_wr_addr = ctl.commit ? idx_ff : count_ff[IW-1:0];
      ram_wr_data = ctl.commit ? (rem_ff - run) : req_burst_time;

      stat.empty    = (count_ff == '0);
      stat.full     = (count_ff == CW'(MAX_PROCESSES));
      stat.hit      = (ram_rd_data != '0);
      stat.last     = ((k_ff + CW'(1)) == count_ff);
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in     = count_ff;
      scan_in      = scan_ff;
      time_in      = time_ff;
      ts_in        = csr_valid ? csr_time_slice : ts_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      rem_in       = ctl.capture ? ram_rd_data : rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_done_in  = rsp_done_ff;

      if (ctl.load) begin
         count_in = count_ff + CW'(1);
      end
      if (ctl.clear) begin
         count_in = '0;
         scan_in  = '0;
         time_in  = '0;
      end
      if (ctl.start) begin
         idx_in = idx_first;
         k_in   = '0;
      end
      if (ctl.advance) begin
         idx_in = idx_next;
         k_in   = k_ff + CW'(1);
      end
      if (ctl.commit) begin
         time_in      = end_sat;
         scan_in      = idx_next;
         rsp_valid_in = 1'b1;
         rsp_id_in    = id_wide[ID_W-1:0];
         rsp_start_in = time_ff;
         rsp_end_in   = end_sat;
         rsp_done_in  = 1'b0;
      end
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         rsp_start_in = time_ff;
         rsp_end_in   = time_ff;
         rsp_done_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         time_ff      <= '0;
         ts_ff        <= TS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         time_ff      <= time_in;
         ts_ff        <= ts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      k_ff         <= k_in;
      rem_ff       <= rem_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_process_id = rsp_id_ff;
   assign rsp_start_time = rsp_start_ff;
   assign rsp_end_time   = rsp_end_ff;
   assign rsp_all_done   = rsp_done_ff;

endmodule

// File: rtl/core/round_robin_slice_scheduler_core.sv
// Top level of the round-robin time-slice scheduler.
// The req channel takes one command item at a time: load appends a burst time to the
// process table, clear empties the table and zeroes the clock, next runs one slice.
// Load and clear finish in the cycle they are accepted and give no result item.
// A next item gives exactly one rsp item: the process run with its start and end
// times, or a done item (process_id 0, all_done 1) when no loaded process has work.
// With an empty table the controller goes straight from idle to its done state.
// Otherwise it passes through the first and scan states, and the scan reads one table
// entry per cycle from the table RAM until a process is found (hit state) or the
// last entry is checked (done state); req_ready is low until it returns to idle.
// The csr channel writes time_slice and is always ready; the user is to use it
// only while idle, which the block itself does not enforce. Reset clears the table
// count, the clock, the scan position and any pending result, and sets time_slice
// to 4. The table contents are not cleared. The result sits in an output register,
// so load and clear items are accepted while a result waits; if rsp_ready stays low,
// a following next item waits in its final state until the register is free.
`timescale 1ns / 1ps
module round_robin_slice_scheduler_core #(
   parameter int MAX_PROCESSES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rrss_pkg::CMD_W-1:0]   req_command,
   input  logic [rrss_pkg::BURST_W-1:0] req_burst_time,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rrss_pkg::ID_W-1:0]    rsp_process_id,
   output logic [rrss_pkg::TIME_W-1:0]  rsp_start_time,
   output logic [rrss_pkg::TIME_W-1:0]  rsp_end_time,
   output logic                         rsp_all_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rrss_pkg::TS_W-1:0]    csr_time_slice
);
   import rrss_pkg::*;

   ctl_type  ctl;
   stat_type stat;

   assign csr_ready = 1'b1;

   rrss_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .stat        (stat),
      .ctl         (ctl)
   );

   rrss_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_burst_time (req_burst_time),
      .csr_valid      (csr_valid),
      .csr_time_slice (csr_time_slice),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_process_id (rsp_process_id),
      .rsp_start_time (rsp_start_time),
      .rsp_end_time   (rsp_end_time),
      .rsp_all_done   (rsp_all_done)
   );

endmodule

// File: rtl/core/rrss_checker.sv
// Port-level checker of the round-robin slice scheduler and its bind.
`timescale 1ns / 1ps
`include "round_robin_slice_scheduler_core_assert.svh"
module rrss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [rrss_pkg::CMD_W-1:0]   req_command,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [rrss_pkg::ID_W-1:0]    rsp_process_id,
   input logic [rrss_pkg::TIME_W-1:0]  rsp_start_time,
   input logic [rrss_pkg::TIME_W-1:0]  rsp_end_time,
   input logic                         rsp_all_done
);
   import rrss_pkg::*;

   // A result item stays offered until it is taken.
   `RRSS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")

   // A done item names no process and spans no time.
   `RRSS_ASSERT(a_done_fields, clock, reset, rsp_valid && rsp_all_done |-> rsp_process_id == '0 && rsp_start_time == rsp_end_time, "bad done item")

   // A slice never ends before it starts.
   `RRSS_ASSERT(a_slice_order, clock, reset, rsp_valid && !rsp_all_done |-> rsp_end_time >= rsp_start_time, "slice ends early")

   // After a next item is taken, req_ready is low in the following cycle.
   `RRSS_ASSERT(a_next_busy, clock, reset, req_valid && req_ready && req_command == CMD_NEXT |=> !req_ready, "ready after next")

   // Reset leaves no result pending.
   `RRSS_ASSERT_ALWAYS(a_reset_clears, clock, $past(reset) |-> !rsp_valid, "rsp valid after reset")

endmodule

bind round_robin_slice_scheduler_core rrss_checker u_rrss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_command    (req_command),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_process_id (rsp_process_id),
   .rsp_start_time (rsp_start_time),
   .rsp_end_time   (rsp_end_time),
   .rsp_all_done   (rsp_all_done)
);
